// ===== src/dual_controller_glcd_interface_macros.svh =====
// assertion helpers for the glcd interface block
`ifndef DUAL_CONTROLLER_GLCD_INTERFACE_MACROS_SVH
`define DUAL_CONTROLLER_GLCD_INTERFACE_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define DCGLCD_ASSERT_IMPLIES(label, cond_a, cond_b) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |-> (cond_b)) \
      else $error("glcd interface check failed");
// next-cycle implication
`define DCGLCD_ASSERT_NEXT(label, cond_a, cond_b) \
   label: assert property (@(posedge clock) disable iff (reset) (cond_a) |=> (cond_b)) \
      else $error("glcd interface check failed");
`else
`define DCGLCD_ASSERT_IMPLIES(label, cond_a, cond_b)
`define DCGLCD_ASSERT_NEXT(label, cond_a, cond_b)
`endif

`endif

// ===== src/dcglcd_pkg.sv =====
package dcglcd_pkg;

   // default sizes
   localparam int HALF_COLUMNS_DEF = 64;
   localparam int QUEUE_DEPTH_DEF  = 4;
   localparam int BEATS_MAX        = 4;

   // request codes
   localparam logic [2:0] REQ_DISPLAY_ON   = 3'd0;
   localparam logic [2:0] REQ_SET_LOCATION = 3'd1;
   localparam logic [2:0] REQ_WRITE_DATA   = 3'd2;
   localparam logic [2:0] REQ_WRITE_PIXEL  = 3'd3;
   localparam logic [2:0] REQ_READ_RETURN  = 3'd4;

   // error codes
   localparam logic [1:0] ERR_NONE   = 2'd0;
   localparam logic [1:0] ERR_COLUMN = 2'd1;
   localparam logic [1:0] ERR_REJECT = 2'd2;

   // controller commands
   localparam logic [7:0] CMD_DISPLAY_ON = 8'h3f;
   localparam logic [7:0] CMD_PAGE       = 8'hb8;
   localparam logic [7:0] CMD_COLUMN     = 8'h40;

   // one bus cycle
   typedef struct packed {
      logic       sel_left;
      logic       sel_right;
      logic       is_data;
      logic       is_read;
      logic [7:0] bus_byte;
      logic [1:0] error;
   } beat_type;

   // all bus cycles of one request
   typedef struct packed {
      logic [$clog2(BEATS_MAX)-1:0] last_idx;
      beat_type [BEATS_MAX-1:0]     beats;
   } entry_type;

   function automatic beat_type make_beat(input logic sl, input logic sr, input logic dat,
                                          input logic rd, input logic [7:0] bus,
                                          input logic [1:0] err);
      beat_type b;
      b.sel_left  = sl;
      b.sel_right = sr;
      b.is_data   = dat;
      b.is_read   = rd;
      b.bus_byte  = bus;
      b.error     = err;
      return b;
   endfunction

endpackage

// ===== src/dcglcd_if.sv =====
interface dcglcd_req_if;
   logic       valid;
   logic       ready;
   logic [2:0] req_type;
   logic [2:0] page;
   logic [6:0] column;
   logic [6:0] row;
   logic [7:0] data_byte;
   logic       pixel_on;

   modport source (output valid, req_type, page, column, row, data_byte, pixel_on,
                   input ready);
   modport sink (input valid, req_type, page, column, row, data_byte, pixel_on,
                 output ready);
endinterface

interface dcglcd_rsp_if;
   logic       valid;
   logic       ready;
   logic       sel_left;
   logic       sel_right;
   logic       is_data;
   logic       is_read;
   logic [7:0] bus_byte;
   logic       last_cycle;
   logic [1:0] error;

   modport source (output valid, sel_left, sel_right, is_data, is_read, bus_byte,
                   last_cycle, error, input ready);
   modport sink (input valid, sel_left, sel_right, is_data, is_read, bus_byte,
                 last_cycle, error, output ready);
endinterface

// ===== src/dcglcd_front.sv =====
module dcglcd_front
   import dcglcd_pkg::*;
#(
   parameter int HALF_COLUMNS = HALF_COLUMNS_DEF
) (
   input  logic         clock,
   input  logic         reset,
   dcglcd_req_if.sink   req_ch,
   output logic         push,
   output entry_type    push_entry,
   input  logic         queue_full
);

   localparam int CUR_W = ($clog2(2*HALF_COLUMNS+1) > 8) ? $clog2(2*HALF_COLUMNS+1) : 8;
   localparam logic [CUR_W-1:0] HALF_C = CUR_W'(HALF_COLUMNS);
   localparam logic [CUR_W-1:0] END_C  = CUR_W'(2*HALF_COLUMNS);

   typedef struct packed {
      logic     past;
      logic     two;
      beat_type first;
      beat_type second;
   } wr_type;

   logic [CUR_W-1:0] cursor_ff, cursor_in;
   logic             await_ff, await_in;
   logic [2:0]       held_page_ff, held_page_in;
   logic [2:0]       held_bit_ff, held_bit_in;
   logic [6:0]       held_column_ff, held_column_in;
   logic             held_value_ff, held_value_in;

   logic             fire;
   logic             reject;
   logic [CUR_W-1:0] col_ext;
   logic [CUR_W-1:0] held_ext;
   logic [5:0]       pix_row;
   logic             pix_left;
   logic [7:0]       held_byte;
   wr_type           wr_cur;
   wr_type           wr_held;
   entry_type        entry;

   // column command to the half that the column selects
   function automatic beat_type col_cmd(input logic [CUR_W-1:0] c);
      logic [CUR_W-1:0] off;
      off = c - HALF_C;
      if (c < HALF_C) begin
         return make_beat(1'b1, 1'b0, 1'b0, 1'b0, CMD_COLUMN | {2'b00, c[5:0]}, ERR_NONE);
      end
      return make_beat(1'b0, 1'b1, 1'b0, 1'b0, CMD_COLUMN | {2'b00, off[5:0]}, ERR_NONE);
   endfunction

   function automatic beat_type page_cmd(input logic [2:0] pg);
      return make_beat(1'b1, 1'b1, 1'b0, 1'b0, CMD_PAGE | {5'b00000, pg}, ERR_NONE);
   endfunction

   // data write at a cursor position, with column command in the right half and an error beat past the end
   function automatic wr_type data_write(input logic [CUR_W-1:0] c, input logic [7:0] b);
      wr_type w;
      w = '0;
      if (c >= END_C) begin
         w.past  = 1'b1;
         w.first = make_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ERR_COLUMN);
      end else if (c < HALF_C) begin
         w.first = make_beat(1'b1, 1'b0, 1'b1, 1'b0, b, ERR_NONE);
      end else begin
         w.two    = 1'b1;
         w.first  = col_cmd(c);
         w.second = make_beat(1'b0, 1'b1, 1'b1, 1'b0, b, ERR_NONE);
      end
      return w;
   endfunction

   // handshake and classification
   assign req_ch.ready = !queue_full;
   assign fire         = req_ch.valid && !queue_full;
   assign reject       = (req_ch.req_type > REQ_READ_RETURN) ||
                         (await_ff != (req_ch.req_type == REQ_READ_RETURN));

   assign col_ext  = CUR_W'(req_ch.column);
   assign held_ext = CUR_W'(held_column_ff);
   assign pix_row  = req_ch.row[5:0] - 6'd1;
   assign pix_left = col_ext < HALF_C;

   // read-modify-write byte
   always_comb begin
      held_byte = req_ch.data_byte;
      held_byte[held_bit_ff] = held_value_ff;
   end

   assign wr_cur  = data_write(cursor_ff, req_ch.data_byte);
   assign wr_held = data_write(held_ext, held_byte);

   // beat list and next state
   always_comb begin
      entry          = '0;
      cursor_in      = cursor_ff;
      await_in       = await_ff;
      held_page_in   = held_page_ff;
      held_bit_in    = held_bit_ff;
      held_column_in = held_column_ff;
      held_value_in  = held_value_ff;
      entry.beats[0] = make_beat(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ERR_REJECT);
      if (!reject) begin
         unique case (req_ch.req_type)
            REQ_DISPLAY_ON: begin
               entry.beats[0] = make_beat(1'b1, 1'b1, 1'b0, 1'b0, CMD_DISPLAY_ON, ERR_NONE);
            end
            REQ_SET_LOCATION: begin
               entry.beats[0] = page_cmd(req_ch.page);
               entry.beats[1] = col_cmd(col_ext);
               entry.last_idx = 2'd1;
               cursor_in      = col_ext;
            end
            REQ_WRITE_DATA: begin
               entry.beats[0] = wr_cur.first;
               entry.beats[1] = wr_cur.second;
               entry.last_idx = {1'b0, wr_cur.two};
               if (!wr_cur.past) begin
                  cursor_in = cursor_ff + 1'b1;
               end
            end
            REQ_WRITE_PIXEL: begin
               entry.beats[0] = page_cmd(pix_row[5:3]);
               entry.beats[1] = col_cmd(col_ext);
               entry.beats[2] = make_beat(pix_left, !pix_left, 1'b1, 1'b1, 8'h00, ERR_NONE);
               entry.beats[3] = make_beat(pix_left, !pix_left, 1'b1, 1'b1, 8'h00, ERR_NONE);
               entry.last_idx = 2'd3;
               cursor_in      = col_ext;
               await_in       = 1'b1;
               held_page_in   = pix_row[5:3];
               held_bit_in    = pix_row[2:0];
               held_column_in = req_ch.column;
               held_value_in  = req_ch.pixel_on;
            end
            REQ_READ_RETURN: begin
               entry.beats[0] = page_cmd(held_page_ff);
               entry.beats[1] = col_cmd(held_ext);
               entry.beats[2] = wr_held.first;
               entry.beats[3] = wr_held.second;
               entry.last_idx = wr_held.two ? 2'd3 : 2'd2;
               await_in       = 1'b0;
               cursor_in      = wr_held.past ? held_ext : held_ext + 1'b1;
            end
            default: begin
               entry.last_idx = 2'd0;
            end
         endcase
      end
   end

   assign push       = fire;
   assign push_entry = entry;

   // state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         cursor_ff      <= '0;
         await_ff       <= 1'b0;
         held_page_ff   <= '0;
         held_bit_ff    <= '0;
         held_column_ff <= '0;
         held_value_ff  <= 1'b0;
      end else if (fire) begin
         cursor_ff      <= cursor_in;
         await_ff       <= await_in;
         held_page_ff   <= held_page_in;
         held_bit_ff    <= held_bit_in;
         held_column_ff <= held_column_in;
         held_value_ff  <= held_value_in;
      end
   end

endmodule

// ===== src/dcglcd_queue.sv =====
module dcglcd_queue
   import dcglcd_pkg::*;
#(
   parameter int QUEUE_DEPTH = QUEUE_DEPTH_DEF
) (
   input  logic      clock,
   input  logic      reset,
   input  logic      push,
   input  entry_type push_entry,
   output logic      full,
   input  logic      pop,
   output logic      head_valid,
   output entry_type head_entry
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH+1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH-1);
   localparam logic [CNT_W-1:0] DEPTH_C  = CNT_W'(QUEUE_DEPTH);

   entry_type        slot_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = count_ff == DEPTH_C;
   assign head_valid = count_ff != '0;
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      end
      case ({do_push, do_pop})
         2'b10:   count_in = count_ff + 1'b1;
         2'b01:   count_in = count_ff - 1'b1;
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

// ===== src/dcglcd_back.sv =====
module dcglcd_back
   import dcglcd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         head_valid,
   input  entry_type    head_entry,
   output logic         pop,
   dcglcd_rsp_if.source rsp_ch
);

   localparam int IDX_W = $clog2(BEATS_MAX);

   logic [IDX_W-1:0] idx_ff, idx_in;
   logic             out_valid_ff, out_valid_in;
   beat_type         beat_ff;
   logic             last_ff;
   logic             load;
   logic             at_last;

   // load the output register when it is empty or being taken
   assign load    = head_valid && (!out_valid_ff || rsp_ch.ready);
   assign at_last = idx_ff == head_entry.last_idx;
   assign pop     = load && at_last;

   always_comb begin
      idx_in       = idx_ff;
      out_valid_in = out_valid_ff && !rsp_ch.ready;
      if (load) begin
         out_valid_in = 1'b1;
         idx_in       = at_last ? '0 : idx_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= '0;
         out_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         out_valid_ff <= out_valid_in;
      end
   end

   // output beat register
   always_ff @(posedge clock) begin
      if (load) begin
         beat_ff <= head_entry.beats[idx_ff];
         last_ff <= at_last;
      end
   end

   assign rsp_ch.valid      = out_valid_ff;
   assign rsp_ch.sel_left   = beat_ff.sel_left;
   assign rsp_ch.sel_right  = beat_ff.sel_right;
   assign rsp_ch.is_data    = beat_ff.is_data;
   assign rsp_ch.is_read    = beat_ff.is_read;
   assign rsp_ch.bus_byte   = beat_ff.bus_byte;
   assign rsp_ch.last_cycle = last_ff;
   assign rsp_ch.error      = beat_ff.error;

endmodule

// ===== src/dual_controller_glcd_interface.sv =====
// Host-side sequencer for a 128x64 graphic LCD built from two column controllers.
// req_ch takes one request per beat (display on, set location, write data,
// write pixel, read return); rsp_ch gives one LCD bus cycle per beat: chip selects,
// command or data, read or write, the byte driven, a last-cycle mark and an error code.
// A request turns into one to four bus cycles; a rejected request or a data write
// past the last column gives a single cycle with both selects low and an error code.
// A write pixel ends with its real read; the host then sends a read return with
// the byte read back, and the block writes the modified byte at the same spot.
// With nothing queued ahead and the output register free, the first bus cycle of a
// request is valid once the queue slot and then the output register have taken it;
// bus cycles of requests queued ahead go out first. The output gives one bus cycle
// per clock while the receiver takes them and the queue holds entries; the front
// takes a request per cycle while the request queue (QUEUE_DEPTH entries) has room,
// and decodes it in that same cycle. When the receiver stalls, the output beat
// holds and the queue fills; req_ch.ready drops once the queue is full. Reset
// clears the cursor, the pending pixel and the queue; no bus cycle is shown until
// a request arrives.
`include "dual_controller_glcd_interface_macros.svh"

module dual_controller_glcd_interface
   import dcglcd_pkg::*;
#(
   parameter int HALF_COLUMNS = HALF_COLUMNS_DEF,
   parameter int QUEUE_DEPTH  = QUEUE_DEPTH_DEF
) (
   input  logic         clock,
   input  logic         reset,
   dcglcd_req_if.sink   req_ch,
   dcglcd_rsp_if.source rsp_ch
);

   logic      push;
   entry_type push_entry;
   logic      queue_full;
   logic      pop;
   logic      head_valid;
   entry_type head_entry;

   // decode requests into bus cycle lists
   dcglcd_front #(
      .HALF_COLUMNS(HALF_COLUMNS)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_ch     (req_ch),
      .push       (push),
      .push_entry (push_entry),
      .queue_full (queue_full)
   );

   // request queue between decode and bus side
   dcglcd_queue #(
      .QUEUE_DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_entry (push_entry),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   // play out bus cycles one per beat
   dcglcd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head_valid (head_valid),
      .head_entry (head_entry),
      .pop        (pop),
      .rsp_ch     (rsp_ch)
   );

   // error cycles stand alone and select no controller
   `DCGLCD_ASSERT_IMPLIES(a_err_alone, rsp_ch.valid && (rsp_ch.error != ERR_NONE), rsp_ch.last_cycle && !rsp_ch.sel_left && !rsp_ch.sel_right)
   // read cycles are data reads with an idle bus byte
   `DCGLCD_ASSERT_IMPLIES(a_read_shape, rsp_ch.valid && rsp_ch.is_read, rsp_ch.is_data && (rsp_ch.bus_byte == 8'h00) && (rsp_ch.error == ERR_NONE))
   // the rest of a request follows right after a taken beat
   `DCGLCD_ASSERT_NEXT(a_no_gap, rsp_ch.valid && rsp_ch.ready && !rsp_ch.last_cycle, rsp_ch.valid)

endmodule

// ===== sim/dcglcd_checker.sv =====
`timescale 1ns / 100ps

// watches both channels, predicts the bus cycles of each request and compares
module dcglcd_checker
   import dcglcd_pkg::*;
(
   input  logic  clock,
   input  logic  reset,
   dcglcd_req_if req_mon,
   dcglcd_rsp_if rsp_mon,
   output int    fail_count,
   output int    pending_count,
   output int    req_count,
   output int    beat_count,
   output int    pixel_count,
   output int    dropped_count,
   output int    reject_count
);

   localparam int         HALF       = HALF_COLUMNS_DEF;
   localparam logic [7:0] END_COLUMN = 8'(2 * HALF);

   // one expected bus cycle with its last-cycle mark
   typedef struct packed {
      beat_type beat;
      logic     last_cycle;
   } lcd_cycle_type;

   lcd_cycle_type expected_cycles[$];

   // mirror of the sequencer state
   logic [7:0] cursor_col;
   logic       awaiting_return;
   logic [2:0] pend_page;
   logic [2:0] pend_bit;
   logic [6:0] pend_col;
   logic       pend_value;

   task automatic push_cycle(input logic sl, input logic sr, input logic dat,
                             input logic rd, input logic [7:0] bus,
                             input logic [1:0] err);
      lcd_cycle_type c;
      c.beat.sel_left  = sl;
      c.beat.sel_right = sr;
      c.beat.is_data   = dat;
      c.beat.is_read   = rd;
      c.beat.bus_byte  = bus;
      c.beat.error     = err;
      c.last_cycle     = 1'b0;
      expected_cycles.push_back(c);
   endtask

   // column command goes to the half the column falls in
   task automatic column_cmd(input logic [7:0] col);
      logic [7:0] offset;
      if (col < 8'(HALF)) begin
         push_cycle(1'b1, 1'b0, 1'b0, 1'b0, CMD_COLUMN | {2'b00, col[5:0]}, ERR_NONE);
      end else begin
         offset = col - 8'(HALF);
         push_cycle(1'b0, 1'b1, 1'b0, 1'b0, CMD_COLUMN | {2'b00, offset[5:0]}, ERR_NONE);
      end
   endtask

   // page to both halves, then the column, and the cursor follows
   task automatic place_cursor(input logic [2:0] pg, input logic [6:0] col);
      push_cycle(1'b1, 1'b1, 1'b0, 1'b0, CMD_PAGE | {5'b00000, pg}, ERR_NONE);
      column_cmd({1'b0, col});
      cursor_col = {1'b0, col};
   endtask

   // data write at the cursor, dropped past the last column
   task automatic write_byte(input logic [7:0] value);
      if (cursor_col >= END_COLUMN) begin
         push_cycle(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ERR_COLUMN);
         dropped_count++;
      end else begin
         if (cursor_col < 8'(HALF)) begin
            push_cycle(1'b1, 1'b0, 1'b1, 1'b0, value, ERR_NONE);
         end else begin
            column_cmd(cursor_col);
            push_cycle(1'b0, 1'b1, 1'b1, 1'b0, value, ERR_NONE);
         end
         cursor_col = cursor_col + 8'd1;
      end
   endtask

   task automatic predict_request(input logic [2:0] t, input logic [2:0] pg,
                                  input logic [6:0] col, input logic [6:0] rw,
                                  input logic [7:0] db, input logic pon);
      logic [6:0]    row_less;
      logic          left;
      logic [7:0]    merged;
      lcd_cycle_type tail;
      if (t > REQ_READ_RETURN || (awaiting_return && t != REQ_READ_RETURN) ||
          (!awaiting_return && t == REQ_READ_RETURN)) begin
         push_cycle(1'b0, 1'b0, 1'b0, 1'b0, 8'h00, ERR_REJECT);
         reject_count++;
      end else begin
         case (t)
            REQ_DISPLAY_ON: begin
               push_cycle(1'b1, 1'b1, 1'b0, 1'b0, CMD_DISPLAY_ON, ERR_NONE);
            end
            REQ_SET_LOCATION: begin
               place_cursor(pg, col);
            end
            REQ_WRITE_DATA: begin
               write_byte(db);
            end
            REQ_WRITE_PIXEL: begin
               // rows count from one and wrap modulo 64
               row_less   = rw - 7'd1;
               left       = (col < 7'(HALF));
               pend_page  = row_less[5:3];
               pend_bit   = row_less[2:0];
               pend_col   = col;
               pend_value = pon;
               place_cursor(pend_page, col);
               // dummy read then real read
               push_cycle(left, ~left, 1'b1, 1'b1, 8'h00, ERR_NONE);
               push_cycle(left, ~left, 1'b1, 1'b1, 8'h00, ERR_NONE);
               awaiting_return = 1'b1;
               pixel_count++;
            end
            default: begin
               // read return: modify one bit and write the byte back
               merged           = db & ~(8'd1 << pend_bit);
               merged[pend_bit] = pend_value;
               awaiting_return  = 1'b0;
               place_cursor(pend_page, pend_col);
               write_byte(merged);
            end
         endcase
      end
      tail = expected_cycles.pop_back();
      tail.last_cycle = 1'b1;
      expected_cycles.push_back(tail);
   endtask

   always @(posedge clock) begin
      lcd_cycle_type want;
      if (reset) begin
         expected_cycles.delete();
         cursor_col      = 8'd0;
         awaiting_return = 1'b0;
         pend_page       = 3'd0;
         pend_bit        = 3'd0;
         pend_col        = 7'd0;
         pend_value      = 1'b0;
         fail_count      = 0;
         req_count       = 0;
         beat_count      = 0;
         pixel_count     = 0;
         dropped_count   = 0;
         reject_count    = 0;
      end else begin
         // results first: a request taken at this edge cannot have a beat out yet
         if (rsp_mon.valid && rsp_mon.ready) begin
            beat_count++;
            if (expected_cycles.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display({"%0t: bus cycle with nothing expected: ",
                            "sl=%b sr=%b d=%b r=%b byte=%h last=%b err=%0d"},
                           $time, rsp_mon.sel_left, rsp_mon.sel_right, rsp_mon.is_data,
                           rsp_mon.is_read, rsp_mon.bus_byte, rsp_mon.last_cycle,
                           rsp_mon.error);
            end else begin
               want = expected_cycles.pop_front();
               if (rsp_mon.sel_left !== want.beat.sel_left ||
                   rsp_mon.sel_right !== want.beat.sel_right ||
                   rsp_mon.is_data !== want.beat.is_data ||
                   rsp_mon.is_read !== want.beat.is_read ||
                   rsp_mon.bus_byte !== want.beat.bus_byte ||
                   rsp_mon.last_cycle !== want.last_cycle ||
                   rsp_mon.error !== want.beat.error) begin
                  fail_count++;
                  if (fail_count <= 10) begin
                     $display("%0t: bus cycle mismatch", $time);
                     $display("   expected sl=%b sr=%b d=%b r=%b byte=%h last=%b err=%0d",
                              want.beat.sel_left, want.beat.sel_right, want.beat.is_data,
                              want.beat.is_read, want.beat.bus_byte, want.last_cycle,
                              want.beat.error);
                     $display("   actual   sl=%b sr=%b d=%b r=%b byte=%h last=%b err=%0d",
                              rsp_mon.sel_left, rsp_mon.sel_right, rsp_mon.is_data,
                              rsp_mon.is_read, rsp_mon.bus_byte, rsp_mon.last_cycle,
                              rsp_mon.error);
                  end
               end
            end
         end
         // then the request accepted at this edge
         if (req_mon.valid && req_mon.ready) begin
            req_count++;
            predict_request(req_mon.req_type, req_mon.page, req_mon.column, req_mon.row,
                            req_mon.data_byte, req_mon.pixel_on);
         end
      end
      pending_count = expected_cycles.size();
   end

endmodule

// ===== sim/tb_dual_controller_glcd_interface.sv =====
`timescale 1ns / 100ps

module tb_dual_controller_glcd_interface
   import dcglcd_pkg::*;
();

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_took;
   logic lcd_busy;
   int   idle_pct;
   int   stall_pct;
   int   items_sent;
   int   chk_fail;
   int   chk_pending;
   int   chk_reqs;
   int   chk_beats;
   int   chk_pixels;
   int   chk_dropped;
   int   chk_rejects;

   int idle_plan[4]  = '{0, 69, 0, 27};
   int stall_plan[4] = '{0, 0, 69, 27};

   dcglcd_req_if req_ch ();
   dcglcd_rsp_if rsp_ch ();

   dual_controller_glcd_interface DUT (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch)
   );

   dcglcd_checker u_check (
      .clock         (clock),
      .reset         (reset),
      .req_mon       (req_ch),
      .rsp_mon       (rsp_ch),
      .fail_count    (chk_fail),
      .pending_count (chk_pending),
      .req_count     (chk_reqs),
      .beat_count    (chk_beats),
      .pixel_count   (chk_pixels),
      .dropped_count (chk_dropped),
      .reject_count  (chk_rejects)
   );

   always #6 clock = ~clock;

   // request beat taken at the last rising edge
   always @(posedge clock) begin
      req_took <= req_ch.valid && req_ch.ready;
   end

   // receiver stalls
   always @(negedge clock) begin
      rsp_ch.ready = ($urandom_range(0, 99) >= stall_pct);
   end

   // watchdog
   initial begin
      #2_000_000;
      $display("timed out with %0d bus cycles outstanding", chk_pending);
      $display("tb_dual_controller_glcd_interface: FAIL");
      $finish;
   end

   // drive one request beat; called and returns at a falling edge
   task automatic send_req(input logic [2:0] t, input logic [2:0] pg, input logic [6:0] col,
                           input logic [6:0] rw, input logic [7:0] db, input logic pon);
      while ($urandom_range(0, 99) < idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.valid     = 1'b1;
      req_ch.req_type  = t;
      req_ch.page      = pg;
      req_ch.column    = col;
      req_ch.row       = rw;
      req_ch.data_byte = db;
      req_ch.pixel_on  = pon;
      do @(negedge clock); while (!req_took);
      items_sent++;
      // track the pending pixel to shape the random sequences
      if (t == REQ_WRITE_PIXEL && !lcd_busy)
         lcd_busy = 1'b1;
      else if (t == REQ_READ_RETURN && lcd_busy)
         lcd_busy = 1'b0;
   endtask

   // request with random content in every field but the type and column
   task automatic send_loose(input logic [2:0] t, input logic [6:0] col);
      send_req(t, 3'($urandom_range(0, 7)), col, 7'($urandom_range(0, 127)),
               8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)));
   endtask

   // stop sending until every expected bus cycle has come out
   task automatic drain;
      req_ch.valid = 1'b0;
      while (chk_pending != 0) @(negedge clock);
   endtask

   task automatic run_random(input int n_items);
      int         goal;
      int         pick;
      int         n_writes;
      logic [6:0] col;
      goal = items_sent + n_items;
      while (items_sent < goal) begin
         pick = $urandom_range(0, 99);
         if (lcd_busy && pick < 75)
            send_loose(REQ_READ_RETURN, 7'($urandom_range(0, 127)));
         if (pick < 40) begin
            // location then a burst of data, often near the right edge
            col = ($urandom_range(0, 99) < 30) ? 7'($urandom_range(118, 127))
                                               : 7'($urandom_range(0, 127));
            send_loose(REQ_SET_LOCATION, col);
            n_writes = $urandom_range(1, 10);
            repeat (n_writes) send_loose(REQ_WRITE_DATA, 7'($urandom_range(0, 127)));
         end else if (pick < 75) begin
            // pixel read-modify-write, sometimes with a request while busy
            send_loose(REQ_WRITE_PIXEL, 7'($urandom_range(0, 127)));
            if ($urandom_range(0, 9) == 0)
               send_loose(3'($urandom_range(0, 3)), 7'($urandom_range(0, 127)));
            send_loose(REQ_READ_RETURN, 7'($urandom_range(0, 127)));
         end else if (pick < 82) begin
            send_loose(REQ_DISPLAY_ON, 7'($urandom_range(0, 127)));
         end else begin
            // noise: any type, including unknown ones and stray read returns
            send_loose(3'($urandom_range(0, 7)), 7'($urandom_range(0, 127)));
         end
      end
   endtask

   initial begin
      req_ch.valid     = 1'b0;
      req_ch.req_type  = REQ_DISPLAY_ON;
      req_ch.page      = 3'd0;
      req_ch.column    = 7'd0;
      req_ch.row       = 7'd0;
      req_ch.data_byte = 8'd0;
      req_ch.pixel_on  = 1'b0;
      idle_pct         = 0;
      stall_pct        = 0;
      items_sent       = 0;
      lcd_busy         = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // directed: commands, both halves, edges, pixel cases, rejects
      send_req(REQ_DISPLAY_ON,   3'd0, 7'd0,   7'd0,   8'h00, 1'b0);
      send_req(REQ_SET_LOCATION, 3'd0, 7'd0,   7'd0,   8'h00, 1'b0);
      send_req(REQ_WRITE_DATA,   3'd0, 7'd0,   7'd0,   8'h00, 1'b0);
      send_req(REQ_WRITE_DATA,   3'd0, 7'd0,   7'd0,   8'hff, 1'b0);
      send_req(REQ_SET_LOCATION, 3'd7, 7'd127, 7'd0,   8'h00, 1'b0);
      send_req(REQ_WRITE_DATA,   3'd0, 7'd0,   7'd0,   8'ha5, 1'b0);
      // cursor now past the last column
      send_req(REQ_WRITE_DATA,   3'd0, 7'd0,   7'd0,   8'h5a, 1'b0);
      send_req(REQ_SET_LOCATION, 3'd3, 7'd64,  7'd0,   8'h00, 1'b0);
      send_req(REQ_WRITE_DATA,   3'd0, 7'd0,   7'd0,   8'h81, 1'b0);
      send_req(REQ_WRITE_PIXEL,  3'd0, 7'd0,   7'd1,   8'h00, 1'b1);
      // busy while the read return is outstanding
      send_req(REQ_DISPLAY_ON,   3'd0, 7'd0,   7'd0,   8'h00, 1'b0);
      send_req(REQ_READ_RETURN,  3'd0, 7'd0,   7'd0,   8'h00, 1'b0);
      // stray read return
      send_req(REQ_READ_RETURN,  3'd0, 7'd0,   7'd0,   8'h3c, 1'b0);
      send_req(REQ_WRITE_PIXEL,  3'd0, 7'd127, 7'd64,  8'h00, 1'b0);
      send_req(REQ_READ_RETURN,  3'd0, 7'd0,   7'd0,   8'hff, 1'b0);
      // row zero wraps to the bottom row
      send_req(REQ_WRITE_PIXEL,  3'd0, 7'd64,  7'd0,   8'h00, 1'b1);
      send_req(REQ_READ_RETURN,  3'd0, 7'd0,   7'd0,   8'h00, 1'b0);
      send_req(REQ_WRITE_PIXEL,  3'd0, 7'd63,  7'd127, 8'h00, 1'b1);
      send_req(REQ_WRITE_DATA,   3'd0, 7'd0,   7'd0,   8'h12, 1'b0);
      send_req(REQ_READ_RETURN,  3'd0, 7'd0,   7'd0,   8'h55, 1'b0);
      // unknown types with every field at its top
      send_req(3'd5,             3'd7, 7'd127, 7'd127, 8'hff, 1'b1);
      send_req(3'd6,             3'd7, 7'd127, 7'd127, 8'hff, 1'b1);
      send_req(3'd7,             3'd7, 7'd127, 7'd127, 8'hff, 1'b1);
      // last left column, then across into the right half
      send_req(REQ_SET_LOCATION, 3'd2, 7'd63,  7'd0,   8'h00, 1'b0);
      send_req(REQ_WRITE_DATA,   3'd0, 7'd0,   7'd0,   8'h7e, 1'b0);
      send_req(REQ_WRITE_DATA,   3'd0, 7'd0,   7'd0,   8'he7, 1'b0);
      drain;

      // random part under each sender idle and receiver stall mix
      for (int p = 0; p < 4; p++) begin
         idle_pct  = idle_plan[p];
         stall_pct = stall_plan[p];
         run_random(65);
         drain;
      end

      stall_pct = 0;
      drain;
      repeat (20) @(negedge clock);

      $display("covered %0d requests (%0d pixel writes, %0d rejected, %0d dropped past end)",
               chk_reqs, chk_pixels, chk_rejects, chk_dropped);
      $display("checked %0d bus cycles under four sender idle and receiver stall mixes",
               chk_beats);
      if (chk_fail == 0 && chk_pending == 0) begin
         $display("tb_dual_controller_glcd_interface: PASS");
      end else begin
         $display("tb_dual_controller_glcd_interface: FAIL");
      end
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/dcglcd_pkg.sv
src/dcglcd_if.sv
src/dcglcd_front.sv
src/dcglcd_queue.sv
src/dcglcd_back.sv
src/dual_controller_glcd_interface.sv
sim/dcglcd_checker.sv
sim/tb_dual_controller_glcd_interface.sv
